FILE: rtl/tgsa_pkg.sv
// ----------------------------------------------------------------------------
// tgsa_pkg
// Shared constants, codes, types and the coordinate mapping function of the
// texel gradient splat accumulator.
// ----------------------------------------------------------------------------
package tgsa_pkg;

    localparam int TEXELS    = 65536;
    localparam int ADDR_W    = $clog2(TEXELS);
    localparam int LANES     = 4;
    localparam int SUM_W     = 48;
    localparam int CNT_W     = 32;
    localparam int VAL_W     = 32;
    localparam int DIV_STEPS = SUM_W;
    localparam int STEP_W    = $clog2(DIV_STEPS + 1);

    localparam logic [1:0] MODE_CLAMP  = 2'd0;
    localparam logic [1:0] MODE_REPEAT = 2'd1;
    localparam logic [1:0] MODE_MIRROR = 2'd2;
    localparam logic [1:0] MODE_ZERO   = 2'd3;

    localparam logic CMD_ACC  = 1'b0;
    localparam logic CMD_READ = 1'b1;

    localparam logic [1:0] REG_MODE     = 2'd0;
    localparam logic [1:0] REG_WIDTH    = 2'd1;
    localparam logic [1:0] REG_HEIGHT   = 2'd2;
    localparam logic [1:0] REG_CHANNELS = 2'd3;

    typedef struct packed {
        logic wr_zero;
        logic wr_acc;
        logic div_start;
    } lane_ctl_t;

    typedef struct packed {
        logic busy;
    } lane_sts_t;

    typedef struct packed {
        logic        ok;
        logic [15:0] frac;
    } map_t;

    function automatic map_t map_coord(input logic [31:0] c, input logic [1:0] mode);
        map_t m;
        m.ok   = 1'b1;
        m.frac = c[15:0];
        case (mode)
            MODE_CLAMP:
            begin
                if (c[31])
                    m.frac = 16'h0000;
                else if (c[30:16] != 15'd0)
                    m.frac = 16'hFFFF;
            end
            MODE_REPEAT:
            begin
                m.frac = c[15:0];
            end
            MODE_MIRROR:
            begin
                if (c[16])
                begin
                    m.ok   = (c[15:0] != 16'd0);
                    m.frac = (~c[15:0]) + 16'd1;
                end
            end
            default:
            begin
                m.ok = (c[31:16] == 16'd0);
            end
        endcase
        return m;
    endfunction

endpackage

FILE: rtl/texel_gradient_splat_accumulator.sv
// ----------------------------------------------------------------------------
// texel_gradient_splat_accumulator
// Scatters gradient splats into per-texel sums and reads back averages, clearing the texel on a read.
// ----------------------------------------------------------------------------
// After reset the block clears every address of its stores before it takes
// the first item; configuration writes are taken throughout. Items are then
// handled one at a time. An accumulate passes through the two-stage address
// unit and the read-modify-write of the stores; a dropped splat skips the
// write. A read also runs the 48-step bit-serial divider that each channel
// lane runs in parallel. The next item is taken once the block returns to
// idle after a result is issued. A result waits in the output register, so
// the next item is taken while it is still unclaimed.
module texel_gradient_splat_accumulator
    import tgsa_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // coord_u, coord_v, grad_c0, grad_c1, grad_c2, grad_c3, texel_index
    input  logic [207:0] s_axis_tdata,
    // command
    input  logic [0:0]   s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // avg_c0, avg_c1, avg_c2, avg_c3, hit_total
    output logic [159:0] m_axis_tdata,
    // accepted
    output logic [0:0]   m_axis_tuser,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [1:0]   cfg_index,
    input  logic [8:0]   cfg_data
);

    typedef enum logic [2:0] {
        S_CLEAR, S_IDLE, S_MAP, S_PIX, S_READ, S_EXEC, S_DIV, S_DONE
    } state_t;

    state_t            state_reg;
    logic [ADDR_W-1:0] clr_reg;
    logic [1:0]        mode_reg;
    logic [8:0]        width_reg;
    logic [8:0]        height_reg;
    logic [2:0]        chan_reg;
    logic              cmd_reg;
    logic [31:0]       u_reg;
    logic [31:0]       v_reg;
    logic [VAL_W-1:0]  grad_reg [LANES];
    logic [ADDR_W-1:0] idx_reg;
    logic              ok_reg;
    logic [CNT_W-1:0]  hit_reg;
    logic              m_valid_reg;
    logic [159:0]      m_data_reg;
    logic              m_user_reg;

    logic [CNT_W-1:0]  cnt_mem [0:TEXELS-1];
    logic [CNT_W-1:0]  cnt_rd_reg;

    logic [8:0]        w_eff;
    logic [8:0]        h_eff;
    logic [2:0]        nc;
    logic [ADDR_W-1:0] pixel;
    logic              pixel_ok;
    logic [ADDR_W-1:0] addr;
    lane_ctl_t         ctl;
    lane_sts_t         sts [LANES];
    logic [VAL_W-1:0]  avg [LANES];
    logic              busy_any;
    logic [CNT_W-1:0]  divisor;
    logic              cnt_we;
    logic [CNT_W-1:0]  cnt_wdata;

    always_comb
    begin
        w_eff = (width_reg == 9'd0) ? 9'd1 : width_reg;
        h_eff = (height_reg == 9'd0) ? 9'd1 : height_reg;
        if (chan_reg == 3'd0)
            nc = 3'd1;
        else if (chan_reg > 3'(LANES))
            nc = 3'(LANES);
        else
            nc = chan_reg;
        if (state_reg == S_CLEAR)
            addr = clr_reg;
        else if (cmd_reg == CMD_READ)
            addr = idx_reg;
        else
            addr = pixel;
        ctl.wr_zero   = (state_reg == S_CLEAR) || (state_reg == S_EXEC && cmd_reg == CMD_READ);
        ctl.wr_acc    = (state_reg == S_EXEC && cmd_reg == CMD_ACC);
        ctl.div_start = (state_reg == S_EXEC && cmd_reg == CMD_READ);
        divisor   = (cnt_rd_reg == '0) ? CNT_W'(1) : cnt_rd_reg;
        cnt_we    = ctl.wr_zero || ctl.wr_acc;
        cnt_wdata = ctl.wr_zero ? '0 :
                    (cnt_rd_reg == '1) ? cnt_rd_reg : cnt_rd_reg + 1'b1;
        busy_any = 1'b0;
        for (int i = 0; i < LANES; i++)
            busy_any = busy_any | sts[i].busy;
    end

    tgsa_coord u_coord
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .coord_u  (u_reg),
        .coord_v  (v_reg),
        .mode     (mode_reg),
        .width    (w_eff),
        .height   (h_eff),
        .pixel    (pixel),
        .pixel_ok (pixel_ok)
    );

    for (genvar g = 0; g < LANES; g++)
    begin : g_lane
        tgsa_lane u_lane
        (
            .clk     (clk),
            .rst_n   (rst_n),
            .addr    (addr),
            .ctl     (ctl),
            .active  (3'(g) < nc),
            .grad    (grad_reg[g]),
            .divisor (divisor),
            .sts     (sts[g]),
            .avg     (avg[g])
        );
    end

    always_ff @(posedge clk)
    begin
        if (cnt_we)
            cnt_mem[addr] <= cnt_wdata;
        cnt_rd_reg <= cnt_mem[addr];
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && s_axis_tvalid)
        begin
            cmd_reg <= s_axis_tuser[0];
            u_reg   <= s_axis_tdata[31:0];
            v_reg   <= s_axis_tdata[63:32];
            for (int i = 0; i < LANES; i++)
                grad_reg[i] <= s_axis_tdata[64 + i*VAL_W +: VAL_W];
            idx_reg <= s_axis_tdata[207:192];
        end
        if (state_reg == S_READ)
            ok_reg <= (cmd_reg == CMD_READ) || pixel_ok;
        if (state_reg == S_EXEC)
            hit_reg <= (cmd_reg == CMD_READ) ? cnt_rd_reg : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_CLEAR;
            clr_reg     <= '0;
            mode_reg    <= MODE_CLAMP;
            width_reg   <= 9'd256;
            height_reg  <= 9'd256;
            chan_reg    <= 3'd4;
            m_valid_reg <= 1'b0;
            m_data_reg  <= '0;
            m_user_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                case (cfg_index)
                    REG_MODE:     mode_reg   <= cfg_data[1:0];
                    REG_WIDTH:    width_reg  <= cfg_data;
                    REG_HEIGHT:   height_reg <= cfg_data;
                    REG_CHANNELS: chan_reg   <= cfg_data[2:0];
                    default:      mode_reg   <= mode_reg;
                endcase
            end
            if (m_valid_reg && m_axis_tready && state_reg != S_DONE)
                m_valid_reg <= 1'b0;
            case (state_reg)
                S_CLEAR:
                begin
                    clr_reg <= clr_reg + 1'b1;
                    if (clr_reg == '1)
                        state_reg <= S_IDLE;
                end
                S_IDLE:
                begin
                    if (s_axis_tvalid)
                        state_reg <= S_MAP;
                end
                S_MAP:
                begin
                    state_reg <= S_PIX;
                end
                S_PIX:
                begin
                    state_reg <= S_READ;
                end
                S_READ:
                begin
                    state_reg <= ((cmd_reg == CMD_READ) || pixel_ok) ? S_EXEC : S_DONE;
                end
                S_EXEC:
                begin
                    state_reg <= (cmd_reg == CMD_READ) ? S_DIV : S_DONE;
                end
                S_DIV:
                begin
                    if (!busy_any)
                        state_reg <= S_DONE;
                end
                S_DONE:
                begin
                    if (!m_valid_reg || m_axis_tready)
                    begin
                        m_valid_reg <= 1'b1;
                        m_user_reg  <= ok_reg;
                        if (ok_reg && cmd_reg == CMD_READ)
                            m_data_reg <= {hit_reg, avg[3], avg[2], avg[1], avg[0]};
                        else
                            m_data_reg <= '0;
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign s_axis_tready = (state_reg == S_IDLE);
    assign cfg_ready     = 1'b1;
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;
    assign m_axis_tuser  = m_user_reg;

    a_clear_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CLEAR) |-> !s_axis_tready)
        else $error("item taken during clearing pass");

    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(state_reg == S_DONE))
        else $error("result appeared outside the completion state");

    a_div_state: assert property (@(posedge clk) disable iff (!rst_n)
        busy_any |-> (state_reg == S_DIV))
        else $error("divider running outside the division state");

    a_drop_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tuser[0]) |-> (m_axis_tdata == '0))
        else $error("dropped item carries data");

endmodule

FILE: rtl/tgsa_coord.sv
// ----------------------------------------------------------------------------
// tgsa_coord
// Two-stage texel address unit: maps both coordinates, scales them to texel
// positions, then forms the row-major texel address.
// ----------------------------------------------------------------------------
module tgsa_coord
    import tgsa_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic [31:0]       coord_u,
    input  logic [31:0]       coord_v,
    input  logic [1:0]        mode,
    input  logic [8:0]        width,
    input  logic [8:0]        height,
    output logic [ADDR_W-1:0] pixel,
    output logic              pixel_ok
);

    map_t        mu;
    map_t        mv;
    logic [24:0] xs;
    logic [24:0] ys;
    logic [8:0]  xc;
    logic [8:0]  yc;
    logic [8:0]  x_reg;
    logic [8:0]  y_reg;
    logic        ok_reg;
    logic [17:0] pix_sum;
    logic [ADDR_W-1:0] pixel_reg;
    logic        pixel_ok_reg;

    always_comb
    begin
        mu = map_coord(coord_u, mode);
        mv = map_coord(coord_v, mode);
        xs = mu.frac * width;
        ys = mv.frac * height;
        xc = (xs[24:16] > width - 9'd1) ? width - 9'd1 : xs[24:16];
        yc = (ys[24:16] > height - 9'd1) ? height - 9'd1 : ys[24:16];
        pix_sum = 18'(y_reg * width) + 18'(x_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ok_reg       <= 1'b0;
            pixel_ok_reg <= 1'b0;
        end
        else
        begin
            ok_reg       <= mu.ok && mv.ok;
            pixel_ok_reg <= ok_reg && (pix_sum[17:16] == 2'd0);
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg     <= xc;
        y_reg     <= yc;
        pixel_reg <= pix_sum[ADDR_W-1:0];
    end

    assign pixel    = pixel_reg;
    assign pixel_ok = pixel_ok_reg;

endmodule

FILE: rtl/tgsa_lane.sv
// ----------------------------------------------------------------------------
// tgsa_lane
// One channel lane: the channel's sum store, the saturating accumulator and
// a bit-serial divider that forms the average on a read.
// ----------------------------------------------------------------------------
module tgsa_lane
    import tgsa_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic [ADDR_W-1:0] addr,
    input  lane_ctl_t         ctl,
    input  logic              active,
    input  logic [VAL_W-1:0]  grad,
    input  logic [CNT_W-1:0]  divisor,
    output lane_sts_t         sts,
    output logic [VAL_W-1:0]  avg
);

    logic [SUM_W-1:0]  mem [0:TEXELS-1];
    logic [SUM_W-1:0]  rd_reg;
    logic [SUM_W:0]    sum_wide;
    logic [SUM_W-1:0]  sum_sat;
    logic [SUM_W-1:0]  wdata;
    logic              we;

    logic [SUM_W-1:0]  quo_reg;
    logic [CNT_W-1:0]  rem_reg;
    logic [CNT_W-1:0]  div_reg;
    logic              neg_reg;
    logic              busy_reg;
    logic [STEP_W-1:0] step_reg;
    logic [CNT_W:0]    rem_sh;
    logic [CNT_W:0]    rem_sub;
    logic              ge;
    logic [VAL_W-1:0]  res;

    always_comb
    begin
        sum_wide = {rd_reg[SUM_W-1], rd_reg} + {{(SUM_W-VAL_W+1){grad[VAL_W-1]}}, grad};
        if (sum_wide[SUM_W] != sum_wide[SUM_W-1])
            sum_sat = {sum_wide[SUM_W], {(SUM_W-1){~sum_wide[SUM_W]}}};
        else
            sum_sat = sum_wide[SUM_W-1:0];
        we    = ctl.wr_zero || (ctl.wr_acc && active);
        wdata = ctl.wr_zero ? '0 : sum_sat;
        rem_sh  = {rem_reg, quo_reg[SUM_W-1]};
        rem_sub = rem_sh - {1'b0, div_reg};
        ge      = (rem_sh >= {1'b0, div_reg});
        if (neg_reg)
        begin
            if (quo_reg > SUM_W'(33'h080000000))
                res = 32'h80000000;
            else
                res = (~quo_reg[VAL_W-1:0]) + 32'd1;
        end
        else
        begin
            if (quo_reg > SUM_W'(32'h7FFFFFFF))
                res = 32'h7FFFFFFF;
            else
                res = quo_reg[VAL_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
            mem[addr] <= wdata;
        rd_reg <= mem[addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= '0;
        end
        else if (ctl.div_start)
        begin
            busy_reg <= 1'b1;
            step_reg <= STEP_W'(DIV_STEPS);
        end
        else if (busy_reg)
        begin
            step_reg <= step_reg - 1'b1;
            if (step_reg == STEP_W'(1))
                busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.div_start)
        begin
            quo_reg <= rd_reg[SUM_W-1] ? (~rd_reg) + 1'b1 : rd_reg;
            neg_reg <= rd_reg[SUM_W-1];
            rem_reg <= '0;
            div_reg <= divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[SUM_W-2:0], ge};
            rem_reg <= ge ? rem_sub[CNT_W-1:0] : rem_sh[CNT_W-1:0];
        end
    end

    assign sts.busy = busy_reg;
    assign avg      = active ? res : '0;

endmodule
